>>> rtl/gce_pkg.sv
// Shared types and constants for the graph connectivity engine.
`timescale 1ns / 1ps

package gce_pkg;

	localparam int VERTEX_W             = 6;
	localparam int CMD_W                = 2;
	localparam int CNT_W                = 7;
	localparam int DEG_W                = 6;
	localparam int S_DATA_W             = 16;
	localparam int M_DATA_W             = 8;
	localparam int DEFAULT_MAX_VERTICES = 64;
	localparam int MATRIX_LIMIT         = 64;

	localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd64;

	typedef enum logic [CMD_W-1:0] {
		CMD_EDGE  = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_CONN  = 2'd2,
		CMD_DEG   = 2'd3
	} gce_cmd_t;

	typedef enum logic [1:0] {
		RD_A    = 2'd0,
		RD_B    = 2'd1,
		RD_PICK = 2'd2
	} gce_rd_sel_t;

	typedef struct packed {
		logic        latch;
		gce_rd_sel_t rd_sel;
		logic        mem_wr;
		logic        wr_b;
		logic        clr_all;
		logic        srch_init;
		logic        srch_pick;
		logic        srch_exp;
		logic        deg_init;
		logic        deg_step;
		logic        out_load;
	} gce_ctl_t;

	typedef struct packed {
		gce_cmd_t cmd;
		logic     ab_ok;
		logic     edge_ok;
		logic     hit;
		logic     pend_any;
		logic     deg_zero;
		logic     out_free;
	} gce_sts_t;

endpackage

>>> rtl/gce_ctrl.sv
// Command sequencer of the graph connectivity engine.
`timescale 1ns / 1ps

module gce_ctrl import gce_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  gce_sts_t sts,
	output gce_ctl_t ctl
);

	typedef enum logic [8:0] {
		ST_IDLE      = 9'b000000001,
		ST_DECODE    = 9'b000000010,
		ST_EDGE_WA   = 9'b000000100,
		ST_EDGE_WB   = 9'b000001000,
		ST_SRCH_PICK = 9'b000010000,
		ST_SRCH_EXP  = 9'b000100000,
		ST_DEG_LOAD  = 9'b001000000,
		ST_DEG_CNT   = 9'b010000000,
		ST_DONE      = 9'b100000000
	} gce_state_t;

	gce_state_t state_q;
	gce_state_t state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		ctl.rd_sel = RD_A;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					ctl.latch = 1'b1;
					state_d   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				ctl.rd_sel = RD_A;
				case (sts.cmd)
					CMD_EDGE: begin
						state_d = sts.edge_ok ? ST_EDGE_WA : ST_IDLE;
					end
					CMD_CLEAR: begin
						ctl.clr_all = 1'b1;
						state_d     = ST_IDLE;
					end
					CMD_CONN: begin
						ctl.srch_init = 1'b1;
						state_d       = sts.ab_ok ? ST_SRCH_PICK : ST_DONE;
					end
					CMD_DEG: begin
						state_d = ST_DEG_LOAD;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_EDGE_WA: begin
				ctl.mem_wr = 1'b1;
				ctl.rd_sel = RD_B;
				state_d    = ST_EDGE_WB;
			end
			ST_EDGE_WB: begin
				ctl.mem_wr = 1'b1;
				ctl.wr_b   = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_SRCH_PICK: begin
				ctl.rd_sel = RD_PICK;
				if (sts.hit || !sts.pend_any) begin
					state_d = ST_DONE;
				end else begin
					ctl.srch_pick = 1'b1;
					state_d       = ST_SRCH_EXP;
				end
			end
			ST_SRCH_EXP: begin
				ctl.srch_exp = 1'b1;
				state_d      = ST_SRCH_PICK;
			end
			ST_DEG_LOAD: begin
				ctl.deg_init = 1'b1;
				state_d      = ST_DEG_CNT;
			end
			ST_DEG_CNT: begin
				if (sts.deg_zero) begin
					state_d = ST_DONE;
				end else begin
					ctl.deg_step = 1'b1;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/gce_datapath.sv
// Adjacency matrix, search bitmaps, degree counter and output register.
`timescale 1ns / 1ps

module gce_datapath import gce_pkg::*; #(
	parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gce_ctl_t            ctl,
	output gce_sts_t            sts,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic [CMD_W-1:0]    s_tuser,
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_wdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tuser
);

	localparam int ROWS  = (MAX_VERTICES < MATRIX_LIMIT) ? MAX_VERTICES : MATRIX_LIMIT;
	localparam int IDX_W = $clog2(ROWS);
	localparam logic [CNT_W-1:0] ROWS_C = CNT_W'(ROWS);

	logic [CNT_W-1:0]    vcount_q;
	gce_cmd_t            cmd_q;
	logic [VERTEX_W-1:0] va_q;
	logic [VERTEX_W-1:0] vb_q;
	logic                ep_q;

	logic [CNT_W-1:0]    n_eff;
	logic [ROWS-1:0]     mask;
	logic                a_ok;
	logic                b_ok;
	logic [IDX_W-1:0]    va_idx;
	logic [IDX_W-1:0]    vb_idx;
	logic [ROWS-1:0]     oh_a;
	logic [ROWS-1:0]     oh_b;

	logic [ROWS-1:0]     mem_q [ROWS];
	logic [ROWS-1:0]     row_vld_q;
	logic [ROWS-1:0]     rd_data_q;
	logic                rd_vld_q;
	logic [ROWS-1:0]     row;
	logic [IDX_W-1:0]    rd_addr;
	logic [IDX_W-1:0]    wr_addr;
	logic [ROWS-1:0]     wr_data;

	logic [ROWS-1:0]     visited_q;
	logic [ROWS-1:0]     pending_q;
	logic [ROWS-1:0]     pend_low;
	logic [IDX_W-1:0]    pick_idx;
	logic [ROWS-1:0]     fresh;

	logic [ROWS-1:0]     deg_sh_q;
	logic [DEG_W-1:0]    deg_q;

	logic                m_tvalid_q;
	logic                kind_q;
	logic                conn_q;
	logic [DEG_W-1:0]    degree_q;
	logic                is_deg;

	assign n_eff  = (vcount_q > ROWS_C) ? ROWS_C : vcount_q;
	assign a_ok   = CNT_W'(va_q) < n_eff;
	assign b_ok   = CNT_W'(vb_q) < n_eff;
	assign va_idx = va_q[IDX_W-1:0];
	assign vb_idx = vb_q[IDX_W-1:0];
	assign oh_a   = ROWS'(1) << va_idx;
	assign oh_b   = ROWS'(1) << vb_idx;

	always_comb begin
		for (int i = 0; i < ROWS; i++) begin
			mask[i] = CNT_W'(i) < n_eff;
		end
	end

	assign pend_low = pending_q & (~pending_q + ROWS'(1));

	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < ROWS; i++) begin
			if (pend_low[i]) begin
				pick_idx = pick_idx | IDX_W'(i);
			end
		end
	end

	always_comb begin
		case (ctl.rd_sel)
			RD_A:    rd_addr = va_idx;
			RD_B:    rd_addr = vb_idx;
			RD_PICK: rd_addr = pick_idx;
			default: rd_addr = va_idx;
		endcase
	end

	assign row     = rd_vld_q ? rd_data_q : '0;
	assign wr_addr = ctl.wr_b ? vb_idx : va_idx;

	always_comb begin
		if (ctl.wr_b) begin
			wr_data = ep_q ? (row | oh_a) : (row & ~oh_a);
		end else begin
			wr_data = ep_q ? (row | oh_b) : (row & ~oh_b);
		end
	end

	assign fresh = row & mask & ~visited_q;

	always_ff @(posedge clk) begin
		if (ctl.mem_wr) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			rd_vld_q <= row_vld_q[rd_addr];
			if (ctl.clr_all) begin
				row_vld_q <= '0;
			end else if (ctl.mem_wr) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RESET;
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= gce_cmd_t'(s_tuser);
			va_q  <= s_tdata[VERTEX_W-1:0];
			vb_q  <= s_tdata[2*VERTEX_W-1:VERTEX_W];
			ep_q  <= s_tdata[2*VERTEX_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			pending_q <= '0;
		end else if (ctl.srch_init) begin
			visited_q <= oh_a;
			pending_q <= oh_a;
		end else if (ctl.srch_pick) begin
			pending_q <= pending_q & ~pend_low;
		end else if (ctl.srch_exp) begin
			visited_q <= visited_q | fresh;
			pending_q <= pending_q | fresh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_sh_q <= '0;
			deg_q    <= '0;
		end else if (ctl.deg_init) begin
			deg_sh_q <= a_ok ? (row & mask) : '0;
			deg_q    <= '0;
		end else if (ctl.deg_step) begin
			deg_sh_q <= deg_sh_q >> 1;
			deg_q    <= deg_q + DEG_W'(deg_sh_q[0]);
		end
	end

	assign is_deg = (cmd_q == CMD_DEG);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			kind_q   <= is_deg;
			conn_q   <= !is_deg && a_ok && b_ok && visited_q[vb_idx];
			degree_q <= is_deg ? deg_q : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {1'b0, degree_q, conn_q};

	assign sts.cmd      = cmd_q;
	assign sts.ab_ok    = a_ok && b_ok;
	assign sts.edge_ok  = a_ok && b_ok && (va_q != vb_q);
	assign sts.hit      = visited_q[vb_idx];
	assign sts.pend_any = |pending_q;
	assign sts.deg_zero = (deg_sh_q == '0);
	assign sts.out_free = !m_tvalid_q || m_tready;

endmodule

>>> rtl/graph_connectivity_engine.sv
// A degree query shifts the neighbor row out bit by bit until no neighbor remains;
// a connectivity query expands one pending vertex per search step until vertex_b is
// reached or none is pending, and skips the search for an out-of-range vertex.
// An edge write updates row a, then row b. Throughput: one word at a time; each search
// step reads one matrix row from the row memory. A finished result waits in the output register.
// Reset clears all edges at once through per-row valid bits; vertex_count resets to 64.
`timescale 1ns / 1ps

module graph_connectivity_engine import gce_pkg::*; #(
	parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // vertex_a[5:0], vertex_b[11:6], edge_present[12]
	input  logic [CMD_W-1:0]    s_tuser,   // cmd[1:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // connected[0], degree[6:1]
	output logic                m_tuser,   // result_kind[0]
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_wdata
);

	gce_ctl_t ctl;
	gce_sts_t sts;

	gce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	gce_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

>>> verif/graph_connectivity_engine_tb.sv
// Self-checking testbench for graph_connectivity_engine: edge writes, clears and queries.
`timescale 1ns / 1ps

module graph_connectivity_engine_tb;
	import gce_pkg::*;

	localparam int          CYCLE_LIMIT = 1000000;
	localparam int          CFG_SETTLE  = 20;
	localparam int          END_SETTLE  = 2 * MATRIX_LIMIT + 12;
	localparam int          PHASE_ITEMS = 75;
	localparam logic        KIND_CONN   = 1'b0;
	localparam logic        KIND_DEG    = 1'b1;

	typedef struct packed {
		logic             kind;
		logic             conn;
		logic [DEG_W-1:0] deg;
	} answer_t;

	class graph_answer_board;
		logic [MATRIX_LIMIT-1:0] rows [MATRIX_LIMIT];
		int unsigned             vcount;
		answer_t                 answers_due [$];
		int unsigned             errors;

		function new();
			foreach (rows[i])
				rows[i] = '0;
			vcount = VCOUNT_RESET;
			errors = 0;
		endfunction

		function void set_count(logic [CNT_W-1:0] v);
			vcount = v;
		endfunction

		function int unsigned live();
			int unsigned n;
			n = vcount;
			if (n > DEFAULT_MAX_VERTICES)
				n = DEFAULT_MAX_VERTICES;
			if (n > MATRIX_LIMIT)
				n = MATRIX_LIMIT;
			return n;
		endfunction

		function logic [MATRIX_LIMIT-1:0] live_mask(int unsigned n);
			if (n >= MATRIX_LIMIT)
				return '1;
			return (64'd1 << n) - 64'd1;
		endfunction

		function logic reaches(int unsigned a, int unsigned b, int unsigned n);
			logic [MATRIX_LIMIT-1:0] mask;
			logic [MATRIX_LIMIT-1:0] seen;
			logic [MATRIX_LIMIT-1:0] grown;
			if (a >= n || b >= n)
				return 1'b0;
			if (a == b)
				return 1'b1;
			mask = live_mask(n);
			seen = 64'd1 << a;
			forever begin
				grown = seen;
				for (int i = 0; i < MATRIX_LIMIT; i++)
					if (seen[i])
						grown |= rows[i] & mask;
				if (grown == seen)
					break;
				seen = grown;
			end
			return seen[b];
		endfunction

		function void take_command(gce_cmd_t cmd, logic [VERTEX_W-1:0] a,
				logic [VERTEX_W-1:0] b, logic present);
			int unsigned n;
			answer_t     ans;
			n   = live();
			ans = '0;
			case (cmd)
				CMD_EDGE: begin
					if (a < n && b < n && a != b) begin
						rows[a][b] = present;
						rows[b][a] = present;
					end
				end
				CMD_CLEAR: begin
					foreach (rows[i])
						rows[i] = '0;
				end
				CMD_CONN: begin
					ans.kind = KIND_CONN;
					ans.conn = reaches(a, b, n);
					answers_due.push_back(ans);
				end
				CMD_DEG: begin
					ans.kind = KIND_DEG;
					if (a < n)
						ans.deg = DEG_W'($countones(rows[a] & live_mask(n)));
					answers_due.push_back(ans);
				end
			endcase
		endfunction

		function void check_answer(logic kind, logic [M_DATA_W-1:0] data);
			answer_t exp;
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected result kind=%0b data=%h", $time, kind, data);
				errors++;
				return;
			end
			exp = answers_due.pop_front();
			if (kind !== exp.kind) begin
				$display("%0t: result_kind expected %0b actual %0b", $time, exp.kind, kind);
				errors++;
			end
			if (data[0] !== exp.conn) begin
				$display("%0t: connected expected %0b actual %0b", $time, exp.conn, data[0]);
				errors++;
			end
			if (data[DEG_W:1] !== exp.deg) begin
				$display("%0t: degree expected %0d actual %0d", $time, exp.deg,
					data[DEG_W:1]);
				errors++;
			end
		endfunction

		function int pending();
			return answers_due.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [CMD_W-1:0]    s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;
	logic                cfg_we;
	logic [CNT_W-1:0]    cfg_wdata;

	graph_answer_board board = new();
	int unsigned       cycles = 0;
	int unsigned       hub;
	bit                src_gaps;
	bit                sink_gaps;
	int unsigned       phase_counts [10] = '{64, 1, 0, 127, 7, 40, 20, 2, 100, 64};

	graph_connectivity_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_answer(m_tuser, m_tdata);
			m_tready <= arst_n && !(sink_gaps && $urandom_range(99) < 15);
		end
	end

	task automatic push_word(input gce_cmd_t cmd, input logic [VERTEX_W-1:0] a,
			input logic [VERTEX_W-1:0] b, input logic present);
		if (src_gaps) begin
			while ($urandom_range(99) < 15) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, present, b, a};
		s_tuser  <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.take_command(cmd, a, b, present);
	endtask

	task automatic settle(input int tail);
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		board.set_count(v);
	endtask

	function automatic int unsigned pick_vertex(input int unsigned n);
		int unsigned lim;
		lim = (n > MATRIX_LIMIT) ? MATRIX_LIMIT : n;
		if (lim == 0)
			return $urandom_range(MATRIX_LIMIT - 1);
		return $urandom_range(lim - 1);
	endfunction

	task automatic random_phase(input int items, input int unsigned n);
		int unsigned pick;
		int unsigned a;
		int unsigned b;
		int unsigned mode;
		int unsigned lim;
		logic        present;
		gce_cmd_t    cmd;
		lim = (n > MATRIX_LIMIT) ? MATRIX_LIMIT : n;
		for (int k = 0; k < items; k++) begin
			pick    = $urandom_range(99);
			a       = pick_vertex(n);
			b       = pick_vertex(n);
			present = ($urandom_range(99) < 75);
			if (pick < 1) begin
				cmd = CMD_CLEAR;
			end else if (pick < 50) begin
				cmd  = CMD_EDGE;
				mode = $urandom_range(9);
				if (mode < 5)
					a = hub;
				else if (mode < 7)
					b = (a + 1 < lim) ? a + 1 : 0;
			end else if (pick < 78) begin
				cmd = CMD_CONN;
			end else begin
				cmd = CMD_DEG;
				if ($urandom_range(1))
					a = hub;
			end
			if ($urandom_range(99) < 8) begin
				a       = $urandom_range(MATRIX_LIMIT - 1);
				b       = $urandom_range(MATRIX_LIMIT - 1);
				present = 1'($urandom_range(1));
			end
			push_word(cmd, VERTEX_W'(a), VERTEX_W'(b), present);
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= CMD_EDGE;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_word(CMD_DEG,   6'd0,  6'd0,  1'b0);
		push_word(CMD_CONN,  6'd0,  6'd0,  1'b0);
		push_word(CMD_CONN,  6'd0,  6'd63, 1'b0);
		push_word(CMD_EDGE,  6'd0,  6'd63, 1'b1);
		push_word(CMD_EDGE,  6'd5,  6'd5,  1'b1);
		push_word(CMD_DEG,   6'd5,  6'd0,  1'b0);
		push_word(CMD_CONN,  6'd0,  6'd63, 1'b0);
		push_word(CMD_DEG,   6'd63, 6'd0,  1'b0);
		push_word(CMD_EDGE,  6'd63, 6'd62, 1'b1);
		push_word(CMD_EDGE,  6'd62, 6'd61, 1'b1);
		push_word(CMD_EDGE,  6'd1,  6'd61, 1'b1);
		push_word(CMD_CONN,  6'd0,  6'd1,  1'b0);
		push_word(CMD_EDGE,  6'd63, 6'd0,  1'b0);
		push_word(CMD_CONN,  6'd0,  6'd1,  1'b0);
		push_word(CMD_CONN,  6'd1,  6'd62, 1'b0);
		push_word(CMD_DEG,   6'd61, 6'd0,  1'b0);
		push_word(CMD_CLEAR, 6'd63, 6'd63, 1'b1);
		push_word(CMD_CONN,  6'd1,  6'd62, 1'b0);
		push_word(CMD_DEG,   6'd61, 6'd0,  1'b0);
		push_word(CMD_EDGE,  6'd42, 6'd21, 1'b1);
		push_word(CMD_DEG,   6'd42, 6'd0,  1'b0);
		push_word(CMD_CONN,  6'd21, 6'd42, 1'b1);
		push_word(CMD_EDGE,  6'd21, 6'd42, 1'b0);
		push_word(CMD_CONN,  6'd42, 6'd21, 1'b0);
		settle(CFG_SETTLE);

		hub = $urandom_range(MATRIX_LIMIT - 1);
		foreach (phase_counts[i]) begin
			if (i > 0)
				write_count(CNT_W'(phase_counts[i]));
			if (hub >= phase_counts[i])
				hub = pick_vertex(phase_counts[i]);
			src_gaps  = (i != 5);
			sink_gaps = (i != 5);
			random_phase(PHASE_ITEMS, phase_counts[i]);
			settle(CFG_SETTLE);
		end

		settle(END_SETTLE);
		if (board.errors == 0 && board.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/gce_pkg.sv
rtl/gce_ctrl.sv
rtl/gce_datapath.sv
rtl/graph_connectivity_engine.sv
verif/graph_connectivity_engine_tb.sv
